/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants and node status codes for the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LOG_TOTAL_DEF = 10;
    localparam int PID_BITS_DEF  = 8;

    // fixed field widths of the request and result channels
    localparam int REQ_W   = 11;
    localparam int PIDIN_W = 8;
    localparam int START_W = 10;
    localparam int SIZE_W  = 11;
    localparam int KLOG_W  = 4;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_FREE   = 2'd1,
        ST_USED   = 2'd2,
        ST_SPLIT  = 2'd3
    } node_stat_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

/* src/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over 2^LOG_TOTAL bytes, tree state held in block memories
// ----------------------------------------------------------------------------
// usage
//   request channel (in_valid/in_ready): mode 0 allocates request_size bytes
//   (rounded up to a power of two) for process_id, mode 1 frees the first
//   block in address order owned by process_id and merges free buddies
//   result channel (out_valid/out_ready): one result transaction per request,
//   success plus start and size of the block; zeros on failure
//   the block tree sits in heap order (node n has children 2n and 2n+1) in a
//   status memory and an owner memory, each one read and one write port with
//   a registered read; the root status lives in a flop
//   the walk does one registered memory read (fetch, then examine) per tree
//   node examined; allocate adds a split and a sibling write per level split,
//   free adds a buddy read and examine per level merged, on top of entry and
//   result handling; an oversize allocate skips the walk and goes straight to
//   the result, while a badly fragmented tree can make the walk visit many
//   more nodes
//   one request is processed at a time; in_ready is high only while idle
//   reset: root becomes one free block; the memories are not cleared since
//   only children of split nodes are ever read and those are written on split
//   a stalled receiver holds the result in the output register; the next
//   request is taken meanwhile and its result waits until the slot empties
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int LOG_TOTAL = LOG_TOTAL_DEF,
    parameter int PID_BITS  = PID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [PIDIN_W-1:0]  process_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                success,
    output logic [START_W-1:0]  block_start,
    output logic [SIZE_W-1:0]   block_size
);

    localparam int AW    = LOG_TOTAL + 1;          // node number width
    localparam int NODES = 2 ** AW;                // entry 0 unused
    localparam int LW    = $clog2(LOG_TOTAL + 1);  // tree level width
    localparam int TW    = $clog2(AW + 1);         // trailing ones count

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EXAM,
        S_SPLIT,
        S_SPLIT_R,
        S_TAKE,
        S_FREE_WR,
        S_MERGE_RD,
        S_MERGE_EX,
        S_OUT
    } state_t;

    // node memories
    node_stat_t             st_mem  [NODES];
    logic [PID_BITS-1:0]    own_mem [NODES];

    node_stat_t             rd_st_reg;
    logic [PID_BITS-1:0]    rd_own_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    node_stat_t             mem_wd;
    logic                   own_we;
    logic [AW-1:0]          rd_addr;

    // control and datapath registers
    state_t                 state_reg, state_next;
    logic [AW-1:0]          nd_reg, nd_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    logic [LW-1:0]          tl_reg, tl_next;
    logic                   mode_reg, mode_next;
    logic [PID_BITS-1:0]    pid_reg, pid_next;
    node_stat_t             root_reg, root_next;
    logic                   res_ok_reg, res_ok_next;
    logic [LOG_TOTAL-1:0]   res_start_reg, res_start_next;
    logic [AW-1:0]          res_size_reg, res_size_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   success_reg, success_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic [SIZE_W-1:0]      size_reg, size_next;

    // combinational helpers
    node_stat_t             cur_st;
    logic [REQ_W-1:0]       req_eff;
    logic [KLOG_W-1:0]      klog;
    logic                   oversize;
    logic [TW-1:0]          tones;
    logic                   tone_stop;
    logic [AW-1:0]          up_nd;
    logic [LW-1:0]          shamt;
    logic [AW-1:0]          nd_off;
    logic [LOG_TOTAL-1:0]   cur_start;
    logic [AW-1:0]          cur_size;
    logic                   is_root;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign block_start = start_reg;
    assign block_size  = size_reg;

    // rounded size as a power-of-two exponent
    always_comb
    begin
        req_eff = (request_size == '0) ? REQ_W'(1) : request_size;
        klog    = '0;
        for (int i = REQ_W; i >= 0; i--)
        begin
            if (((REQ_W+1)'(1) << i) >= {1'b0, req_eff})
            begin
                klog = KLOG_W'(i);
            end
        end
        oversize = (int'(klog) > LOG_TOTAL);
    end

    // next node in address order after a failed subtree: climb over right
    // children, then step to the right sibling
    always_comb
    begin
        tones     = '0;
        tone_stop = 1'b0;
        for (int i = 0; i < AW; i++)
        begin
            if (!tone_stop && nd_reg[i])
            begin
                tones = tones + TW'(1);
            end
            else
            begin
                tone_stop = 1'b1;
            end
        end
        up_nd = nd_reg >> tones;
    end

    // address range of the current node
    always_comb
    begin
        is_root   = (nd_reg == AW'(1));
        cur_st    = is_root ? root_reg : rd_st_reg;
        shamt     = LW'(LOG_TOTAL) - lvl_reg;
        nd_off    = nd_reg ^ (AW'(1) << lvl_reg);
        cur_start = LOG_TOTAL'(nd_off << shamt);
        cur_size  = AW'(1) << shamt;
    end

    always_comb
    begin
        state_next     = state_reg;
        nd_next        = nd_reg;
        lvl_next       = lvl_reg;
        tl_next        = tl_reg;
        mode_next      = mode_reg;
        pid_next       = pid_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        res_size_next  = res_size_reg;
        out_valid_next = out_valid_reg;
        success_next   = success_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        mem_we         = 1'b0;
        mem_wa         = nd_reg;
        mem_wd         = ST_FREE;
        own_we         = 1'b0;
        rd_addr        = nd_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next      = mode;
                    pid_next       = PID_BITS'(process_id);
                    tl_next        = LW'(LOG_TOTAL - int'(klog));
                    nd_next        = AW'(1);
                    lvl_next       = '0;
                    res_ok_next    = 1'b0;
                    res_start_next = '0;
                    res_size_next  = '0;
                    if (mode == MODE_ALLOC && oversize)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                rd_addr    = nd_reg;
                state_next = S_EXAM;
            end

            S_EXAM:
            begin
                priority if (mode_reg == MODE_ALLOC && cur_st == ST_FREE)
                begin
                    state_next = (lvl_reg == tl_reg) ? S_TAKE : S_SPLIT;
                end
                else if (mode_reg == MODE_FREE && cur_st == ST_USED
                         && rd_own_reg == pid_reg)
                begin
                    res_ok_next    = 1'b1;
                    res_start_next = cur_start;
                    res_size_next  = cur_size;
                    state_next     = S_FREE_WR;
                end
                else if (cur_st == ST_SPLIT
                         && ((mode_reg == MODE_ALLOC && lvl_reg < tl_reg)
                          || (mode_reg == MODE_FREE && int'(lvl_reg) < LOG_TOTAL)))
                begin
                    nd_next    = nd_reg << 1;
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = S_FETCH;
                end
                else if (up_nd == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    nd_next    = up_nd + AW'(1);
                    lvl_next   = lvl_reg - LW'(tones);
                    state_next = S_FETCH;
                end
            end

            // split a free block one level down toward the target size
            S_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_wa     = nd_reg;
                mem_wd     = ST_SPLIT;
                state_next = S_SPLIT_R;
            end

            S_SPLIT_R:
            begin
                mem_we     = 1'b1;
                mem_wa     = {nd_reg[AW-2:0], 1'b1};
                mem_wd     = ST_FREE;
                nd_next    = nd_reg << 1;
                lvl_next   = lvl_reg + LW'(1);
                state_next = (lvl_reg + LW'(1) == tl_reg) ? S_TAKE : S_SPLIT;
            end

            S_TAKE:
            begin
                mem_we         = 1'b1;
                mem_wa         = nd_reg;
                mem_wd         = ST_USED;
                own_we         = 1'b1;
                res_ok_next    = 1'b1;
                res_start_next = cur_start;
                res_size_next  = cur_size;
                state_next     = S_OUT;
            end

            S_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = nd_reg;
                mem_wd     = ST_FREE;
                state_next = is_root ? S_OUT : S_MERGE_RD;
            end

            S_MERGE_RD:
            begin
                rd_addr    = nd_reg ^ AW'(1);
                state_next = S_MERGE_EX;
            end

            // buddy free too: parent becomes one free block
            S_MERGE_EX:
            begin
                if (rd_st_reg == ST_FREE)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = nd_reg >> 1;
                    mem_wd     = ST_FREE;
                    nd_next    = nd_reg >> 1;
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ((nd_reg >> 1) == AW'(1)) ? S_OUT : S_MERGE_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    success_next   = res_ok_reg;
                    start_next     = START_W'(res_start_reg);
                    size_next      = SIZE_W'(res_size_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        root_next = root_reg;
        if (mem_we && mem_wa == AW'(1))
        begin
            root_next = mem_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            root_reg      <= ST_FREE;
            nd_reg        <= AW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        tl_reg        <= tl_next;
        mode_reg      <= mode_next;
        pid_reg       <= pid_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        res_size_reg  <= res_size_next;
        success_reg   <= success_next;
        start_reg     <= start_next;
        size_reg      <= size_next;
    end

    // node memories, write-first bypass on same-address access
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            st_mem[mem_wa] <= mem_wd;
        end
        if (own_we)
        begin
            own_mem[mem_wa] <= pid_reg;
        end
        rd_st_reg  <= (mem_we && mem_wa == rd_addr) ? mem_wd : st_mem[rd_addr];
        rd_own_reg <= (own_we && mem_wa == rd_addr) ? pid_reg : own_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_root_live: assert property (@(posedge clk) disable iff (!rst_n)
        root_reg != ST_UNUSED)
        else $error("root node marked unused");

    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg != '0)
        else $error("node number zero");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> block_start == '0 && block_size == '0)
        else $error("failed result carries a block");

    a_split_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |=> state_reg == S_SPLIT_R)
        else $error("split not followed by sibling write");
`endif

endmodule
